### hdl/c2v_pkg.sv
`default_nettype none
package c2v_pkg;

   localparam int DEF_CHANNELS   = 8;
   localparam int DEF_VOL_DEPTH  = 16;
   localparam int DEF_VOL_HEIGHT = 16;
   localparam int DEF_VOL_WIDTH  = 16;
   localparam int DEF_DIL_DEPTH  = 1;

   localparam int CMD_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 4;
   localparam int SAMPLE_W    = 16;
   localparam int VOXEL_W     = 32;
   localparam int OP_W        = 2;
   localparam int COORD_W     = 12;

   localparam logic [1:0] REQ_ACCUM      = 2'd0;
   localparam logic [1:0] REQ_READ       = 2'd1;
   localparam logic [1:0] REQ_READ_CLEAR = 2'd2;

   localparam logic [OP_W-1:0] OP_ACCUM      = 2'd0;
   localparam logic [OP_W-1:0] OP_READ       = 2'd1;
   localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_READ_ZERO  = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_STRIDE_DEPTH    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIDE_HEIGHT   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIDE_WIDTH    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAD_DEPTH       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAD_HEIGHT      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAD_WIDTH       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DILATION_HEIGHT = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_DILATION_WIDTH  = 3'd7;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] stride_depth;
      logic [CSR_DATA_W-1:0] stride_height;
      logic [CSR_DATA_W-1:0] stride_width;
      logic [CSR_DATA_W-1:0] pad_depth;
      logic [CSR_DATA_W-1:0] pad_height;
      logic [CSR_DATA_W-1:0] pad_width;
      logic [CSR_DATA_W-1:0] dilation_height;
      logic [CSR_DATA_W-1:0] dilation_width;
   } csr_type;

   localparam csr_type CSR_RESET = '{
      stride_depth:    4'd1,
      stride_height:   4'd1,
      stride_width:    4'd1,
      pad_depth:       4'd0,
      pad_height:      4'd0,
      pad_width:       4'd0,
      dilation_height: 4'd1,
      dilation_width:  4'd1
   };

   function automatic int field_bits(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   function automatic logic signed [COORD_W-1:0] axis_coord(
      input logic [5:0] pos,
      input logic [3:0] stride,
      input logic [2:0] off,
      input logic [3:0] dil,
      input logic [3:0] pad
   );
      logic [9:0] prod_pos;
      logic [6:0] prod_off;
      prod_pos = 10'(pos) * 10'(stride);
      prod_off = 7'(off) * 7'(dil);
      return $signed({2'b00, prod_pos}) + $signed({5'b00000, prod_off})
             - $signed({8'h00, pad});
   endfunction

endpackage
`default_nettype wire

### hdl/c2v_ram.sv
`default_nettype none
module c2v_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

### hdl/c2v_fifo.sv
`default_nettype none
module c2v_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

### hdl/c2v_front.sv
`default_nettype none
module c2v_front import c2v_pkg::*; #(
   parameter int CHANNELS   = DEF_CHANNELS,
   parameter int VOL_DEPTH  = DEF_VOL_DEPTH,
   parameter int VOL_HEIGHT = DEF_VOL_HEIGHT,
   parameter int VOL_WIDTH  = DEF_VOL_WIDTH,
   parameter int DIL_DEPTH  = DEF_DIL_DEPTH,
   parameter int ADDR_W     = 15
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_push,
   input  wire logic                   stall,
   input  wire logic [1:0]             req_type,
   input  wire logic [2:0]             req_channel,
   input  wire logic [2:0]             req_kern_dep,
   input  wire logic [2:0]             req_kern_row,
   input  wire logic [2:0]             req_kern_col,
   input  wire logic [5:0]             req_out_dep,
   input  wire logic [5:0]             req_out_row,
   input  wire logic [5:0]             req_out_col,
   input  wire logic [SAMPLE_W-1:0]    req_sample,
   input  wire logic [3:0]             req_vox_dep,
   input  wire logic [3:0]             req_vox_row,
   input  wire logic [3:0]             req_vox_col,
   output logic                        cmd_push,
   output logic      [OP_W-1:0]        cmd_op,
   output logic      [ADDR_W-1:0]      cmd_addr,
   output logic      [SAMPLE_W-1:0]    cmd_sample
);

   localparam int CH_AW = field_bits(CHANNELS);
   localparam int D_AW  = field_bits(VOL_DEPTH);
   localparam int H_AW  = field_bits(VOL_HEIGHT);
   localparam int W_AW  = field_bits(VOL_WIDTH);

   localparam logic [6:0]         CH_LIM = 7'(CHANNELS);
   localparam logic [COORD_W-1:0] D_LIM  = COORD_W'(VOL_DEPTH);
   localparam logic [COORD_W-1:0] H_LIM  = COORD_W'(VOL_HEIGHT);
   localparam logic [COORD_W-1:0] W_LIM  = COORD_W'(VOL_WIDTH);
   localparam logic [3:0]         DIL_D  = 4'(DIL_DEPTH);

   csr_type csr_ff;

   logic signed [COORD_W-1:0] coord_d, coord_r, coord_w;
   logic                      ch_ok, d_ok, r_ok, w_ok, vox_ok, keep;
   logic [ADDR_W-1:0]         acc_addr, rd_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STRIDE_DEPTH:    csr_ff.stride_depth    <= csr_wdata;
            CSR_STRIDE_HEIGHT:   csr_ff.stride_height   <= csr_wdata;
            CSR_STRIDE_WIDTH:    csr_ff.stride_width    <= csr_wdata;
            CSR_PAD_DEPTH:       csr_ff.pad_depth       <= csr_wdata;
            CSR_PAD_HEIGHT:      csr_ff.pad_height      <= csr_wdata;
            CSR_PAD_WIDTH:       csr_ff.pad_width       <= csr_wdata;
            CSR_DILATION_HEIGHT: csr_ff.dilation_height <= csr_wdata;
            CSR_DILATION_WIDTH:  csr_ff.dilation_width  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign coord_d = axis_coord(req_out_dep, csr_ff.stride_depth, req_kern_dep, DIL_D,
                               csr_ff.pad_depth);
   assign coord_r = axis_coord(req_out_row, csr_ff.stride_height, req_kern_row,
                               csr_ff.dilation_height, csr_ff.pad_height);
   assign coord_w = axis_coord(req_out_col, csr_ff.stride_width, req_kern_col,
                               csr_ff.dilation_width, csr_ff.pad_width);

   assign ch_ok = ({4'h0, req_channel} < CH_LIM);
   assign d_ok  = !coord_d[COORD_W-1] && ($unsigned(coord_d) < D_LIM);
   assign r_ok  = !coord_r[COORD_W-1] && ($unsigned(coord_r) < H_LIM);
   assign w_ok  = !coord_w[COORD_W-1] && ($unsigned(coord_w) < W_LIM);

   assign vox_ok = ch_ok
                   && ({8'h00, req_vox_dep} < D_LIM)
                   && ({8'h00, req_vox_row} < H_LIM)
                   && ({8'h00, req_vox_col} < W_LIM);

   assign acc_addr = {CH_AW'(req_channel), D_AW'(coord_d[COORD_W-2:0]),
                      H_AW'(coord_r[COORD_W-2:0]), W_AW'(coord_w[COORD_W-2:0])};
   assign rd_addr  = {CH_AW'(req_channel), D_AW'(req_vox_dep),
                      H_AW'(req_vox_row), W_AW'(req_vox_col)};

   always_comb begin
      keep     = 1'b0;
      cmd_op   = OP_ACCUM;
      cmd_addr = acc_addr;
      case (req_type)
         REQ_ACCUM: begin
            keep = ch_ok && d_ok && r_ok && w_ok;
         end
         REQ_READ: begin
            keep     = 1'b1;
            cmd_op   = vox_ok ? OP_READ : OP_READ_ZERO;
            cmd_addr = rd_addr;
         end
         REQ_READ_CLEAR: begin
            keep     = 1'b1;
            cmd_op   = vox_ok ? OP_READ_CLEAR : OP_READ_ZERO;
            cmd_addr = rd_addr;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign cmd_push   = req_push && !stall && keep;
   assign cmd_sample = req_sample;

endmodule
`default_nettype wire

### hdl/c2v_back.sv
`default_nettype none
module c2v_back import c2v_pkg::*; #(
   parameter int ADDR_W = 15
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                cmd_empty,
   input  wire logic [OP_W-1:0]     cmd_op,
   input  wire logic [ADDR_W-1:0]   cmd_addr,
   input  wire logic [SAMPLE_W-1:0] cmd_sample,
   output logic                     cmd_pop,
   input  wire logic                rsp_full,
   output logic                     rsp_push,
   output logic      [VOXEL_W-1:0]  rsp_data,
   output logic                     clearing
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;

   logic                ram_we, ram_re;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [VOXEL_W-1:0]  ram_wdata, ram_rdata;

   logic [VOXEL_W:0]    sum;
   logic [VOXEL_W-1:0]  sat_sum;

   c2v_ram #(
      .WIDTH (VOXEL_W),
      .DEPTH (2 ** ADDR_W)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (cmd_addr),
      .rdata (ram_rdata)
   );

   assign sum = {ram_rdata[VOXEL_W-1], ram_rdata}
              + {{(VOXEL_W - SAMPLE_W - 7){sample_ff[SAMPLE_W-1]}}, sample_ff, 8'h00};

   always_comb begin
      if (sum[VOXEL_W] != sum[VOXEL_W-1]) begin
         sat_sum = sum[VOXEL_W] ? {1'b1, {(VOXEL_W-1){1'b0}}} : {1'b0, {(VOXEL_W-1){1'b1}}};
      end else begin
         sat_sum = sum[VOXEL_W-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      op_in     = op_ff;
      addr_in   = addr_ff;
      sample_in = sample_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = '0;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      rsp_data  = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop   = 1'b1;
               ram_re    = 1'b1;
               op_in     = cmd_op;
               addr_in   = cmd_addr;
               sample_in = cmd_sample;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_IDLE;
            case (op_ff)
               OP_ACCUM: begin
                  ram_we    = 1'b1;
                  ram_wdata = sat_sum;
               end
               OP_READ: begin
                  rsp_push = 1'b1;
                  rsp_data = ram_rdata;
               end
               OP_READ_CLEAR: begin
                  rsp_push = 1'b1;
                  rsp_data = ram_rdata;
                  ram_we   = 1'b1;
               end
               OP_READ_ZERO: begin
                  rsp_push = 1'b1;
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      addr_ff   <= addr_in;
      sample_ff <= sample_in;
   end

   assign clearing = (state_ff == ST_CLEAR);

endmodule
`default_nettype wire

### hdl/col2vol_scatter_accumulate.sv
// Scatter-accumulate for 3D col2im. Each accumulate beat maps a Q8.8 column element to a
// voxel (out_pos * stride + kern_off * dilation - pad per axis), drops it when out of range,
// and adds it into the Q16.16 voxel store with saturation; read beats return one voxel and
// optionally clear it. The front classifies one beat per cycle, while req_full is low, into
// a four-entry command queue; the back runs each command as a read-modify-write on the
// single-read-port store and takes no new command until the last one is done. Dropped
// elements and ignored request types never reach the back. After reset the store is zeroed
// in a clearing pass over all 2**(sum of the field address widths) entries, 32768 at the
// default geometry, while req_full stays high; configuration writes are taken throughout.
// Voxels are addressed as {channel, depth, row, column} with each field padded to a power
// of two.
`default_nettype none
module col2vol_scatter_accumulate import c2v_pkg::*; #(
   parameter int CHANNELS   = DEF_CHANNELS,
   parameter int VOL_DEPTH  = DEF_VOL_DEPTH,
   parameter int VOL_HEIGHT = DEF_VOL_HEIGHT,
   parameter int VOL_WIDTH  = DEF_VOL_WIDTH,
   parameter int DIL_DEPTH  = DEF_DIL_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire logic [1:0]             req_type,
   input  wire logic [2:0]             req_channel,
   input  wire logic [2:0]             req_kern_dep,
   input  wire logic [2:0]             req_kern_row,
   input  wire logic [2:0]             req_kern_col,
   input  wire logic [5:0]             req_out_dep,
   input  wire logic [5:0]             req_out_row,
   input  wire logic [5:0]             req_out_col,
   input  wire logic [SAMPLE_W-1:0]    req_sample,
   input  wire logic [3:0]             req_vox_dep,
   input  wire logic [3:0]             req_vox_row,
   input  wire logic [3:0]             req_vox_col,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic      [VOXEL_W-1:0]     rsp_voxel_value
);

   localparam int ADDR_W = field_bits(CHANNELS) + field_bits(VOL_DEPTH)
                         + field_bits(VOL_HEIGHT) + field_bits(VOL_WIDTH);
   localparam int CMD_W  = OP_W + ADDR_W + SAMPLE_W;

   logic                cmd_push, cmd_full, cmd_empty, cmd_pop;
   logic [OP_W-1:0]     front_op, back_op;
   logic [ADDR_W-1:0]   front_addr, back_addr;
   logic [SAMPLE_W-1:0] front_sample, back_sample;
   logic                clearing;
   logic                rsp_push, rsp_full;
   logic [VOXEL_W-1:0]  rsp_data;

   assign req_full = cmd_full || clearing;

   c2v_front #(
      .CHANNELS   (CHANNELS),
      .VOL_DEPTH  (VOL_DEPTH),
      .VOL_HEIGHT (VOL_HEIGHT),
      .VOL_WIDTH  (VOL_WIDTH),
      .DIL_DEPTH  (DIL_DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_push     (req_push),
      .stall        (req_full),
      .req_type     (req_type),
      .req_channel  (req_channel),
      .req_kern_dep (req_kern_dep),
      .req_kern_row (req_kern_row),
      .req_kern_col (req_kern_col),
      .req_out_dep  (req_out_dep),
      .req_out_row  (req_out_row),
      .req_out_col  (req_out_col),
      .req_sample   (req_sample),
      .req_vox_dep  (req_vox_dep),
      .req_vox_row  (req_vox_row),
      .req_vox_col  (req_vox_col),
      .cmd_push     (cmd_push),
      .cmd_op       (front_op),
      .cmd_addr     (front_addr),
      .cmd_sample   (front_sample)
   );

   c2v_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata ({front_op, front_addr, front_sample}),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata ({back_op, back_addr, back_sample}),
      .empty (cmd_empty)
   );

   c2v_back #(
      .ADDR_W (ADDR_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_empty  (cmd_empty),
      .cmd_op     (back_op),
      .cmd_addr   (back_addr),
      .cmd_sample (back_sample),
      .cmd_pop    (cmd_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_data),
      .clearing   (clearing)
   );

   c2v_fifo #(
      .WIDTH (VOXEL_W),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_data),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_voxel_value),
      .empty (rsp_empty)
   );

endmodule
`default_nettype wire

### hdl/c2v_checker.sv
`default_nettype none
module c2v_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_push,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [31:0] rsp_voxel_value
);

   // hold off input while the store is being zeroed
   a_full_after_reset: assert property (@(posedge clock) reset |=> req_full)
      else $error("req_full low right after reset");

   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result present right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_voxel_value)))
      else $error("waiting result changed or vanished without pop");

   // a result needs at least a read and a write-back out of reset
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> (!$past(reset) && !$past(reset, 2)))
      else $error("result appeared too soon after reset");

   a_push_known: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> !$isunknown(rsp_empty))
      else $error("rsp_empty unknown after accepted beat");

endmodule

bind col2vol_scatter_accumulate c2v_checker u_checker (.*);
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import c2v_pkg::*;

   localparam logic [1:0] REQ_IGNORED = 2'd3;
   localparam int VOXELS        = DEF_CHANNELS * DEF_VOL_DEPTH * DEF_VOL_HEIGHT * DEF_VOL_WIDTH;
   localparam int DRAIN_CYCLES  = 40;
   localparam int WATCHDOG_IDLE = 100000;
   localparam int HAMMER_BEATS  = 270;

   typedef struct {
      logic [1:0]                 kind;
      logic [2:0]                 channel;
      logic [2:0]                 kern_dep;
      logic [2:0]                 kern_row;
      logic [2:0]                 kern_col;
      logic [5:0]                 out_dep;
      logic [5:0]                 out_row;
      logic [5:0]                 out_col;
      logic signed [SAMPLE_W-1:0] sample;
      logic [3:0]                 vox_dep;
      logic [3:0]                 vox_row;
      logic [3:0]                 vox_col;
   } voxel_req_type;

   typedef struct {
      voxel_req_type rq;
      bit            typed;
      logic [31:0]   value;
   } script_row_type;

   typedef enum {POP_ALWAYS, POP_HALF, POP_RARE, POP_PULSED} pop_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic req_push = 1'b0;
   logic req_full;
   logic [1:0] req_type = '0;
   logic [2:0] req_channel = '0;
   logic [2:0] req_kern_dep = '0;
   logic [2:0] req_kern_row = '0;
   logic [2:0] req_kern_col = '0;
   logic [5:0] req_out_dep = '0;
   logic [5:0] req_out_row = '0;
   logic [5:0] req_out_col = '0;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic [3:0] req_vox_dep = '0;
   logic [3:0] req_vox_row = '0;
   logic [3:0] req_vox_col = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [VOXEL_W-1:0] rsp_voxel_value;

   col2vol_scatter_accumulate DUT (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_push(req_push),
      .req_full(req_full),
      .req_type(req_type),
      .req_channel(req_channel),
      .req_kern_dep(req_kern_dep),
      .req_kern_row(req_kern_row),
      .req_kern_col(req_kern_col),
      .req_out_dep(req_out_dep),
      .req_out_row(req_out_row),
      .req_out_col(req_out_col),
      .req_sample(req_sample),
      .req_vox_dep(req_vox_dep),
      .req_vox_row(req_vox_row),
      .req_vox_col(req_vox_col),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_voxel_value(rsp_voxel_value)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   csr_type            geometry = CSR_RESET;
   logic signed [31:0] acc_store [VOXELS];
   int                 landed_voxels [$];
   logic [31:0]        pending_voxels [$];
   script_row_type     script [$];

   int           fail_count = 0;
   int           reads_checked = 0;
   int           items_sent = 0;
   int           landed = 0;
   int           saturated = 0;
   int           configs_used = 0;
   int           burst_left = 1;
   int           idle_cycles = 0;
   int           stall_tick = 0;
   pop_mode_type stall_mode = POP_ALWAYS;
   logic [31:0]  want;

   initial begin
      foreach (acc_store[i]) acc_store[i] = '0;
   end

   function automatic void flag_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endfunction

   function automatic int voxel_at(input int ch, input int d, input int r, input int w);
      return ((ch * DEF_VOL_DEPTH + d) * DEF_VOL_HEIGHT + r) * DEF_VOL_WIDTH + w;
   endfunction

   // Return 1 when the request yields a voxel beat; update the shadow volume.
   function automatic bit step_volume(input voxel_req_type rq, output logic [31:0] value);
      int     dep, row, col, idx;
      longint sum;
      value = '0;
      case (rq.kind)
         REQ_ACCUM: begin
            dep = int'(rq.out_dep) * int'(geometry.stride_depth)
                  + int'(rq.kern_dep) * DEF_DIL_DEPTH - int'(geometry.pad_depth);
            row = int'(rq.out_row) * int'(geometry.stride_height)
                  + int'(rq.kern_row) * int'(geometry.dilation_height)
                  - int'(geometry.pad_height);
            col = int'(rq.out_col) * int'(geometry.stride_width)
                  + int'(rq.kern_col) * int'(geometry.dilation_width)
                  - int'(geometry.pad_width);
            if (int'(rq.channel) < DEF_CHANNELS && dep >= 0 && dep < DEF_VOL_DEPTH &&
                row >= 0 && row < DEF_VOL_HEIGHT && col >= 0 && col < DEF_VOL_WIDTH) begin
               idx = voxel_at(int'(rq.channel), dep, row, col);
               sum = longint'(acc_store[idx]) + longint'(rq.sample) * 256;
               if (sum > 64'sd2147483647) begin
                  sum = 64'sd2147483647;
                  saturated++;
               end else if (sum < -64'sd2147483648) begin
                  sum = -64'sd2147483648;
                  saturated++;
               end
               acc_store[idx] = 32'(sum);
               landed++;
               landed_voxels.push_back(idx);
               if (landed_voxels.size() > 64) void'(landed_voxels.pop_front());
            end
            return 1'b0;
         end
         REQ_READ, REQ_READ_CLEAR: begin
            if (int'(rq.channel) < DEF_CHANNELS && int'(rq.vox_dep) < DEF_VOL_DEPTH &&
                int'(rq.vox_row) < DEF_VOL_HEIGHT && int'(rq.vox_col) < DEF_VOL_WIDTH) begin
               idx = voxel_at(int'(rq.channel), int'(rq.vox_dep), int'(rq.vox_row),
                              int'(rq.vox_col));
               value = acc_store[idx];
               if (rq.kind == REQ_READ_CLEAR) acc_store[idx] = '0;
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic voxel_req_type make_req(
      input logic [1:0] kind, input logic [2:0] ch,
      input logic [2:0] kd, input logic [2:0] kr, input logic [2:0] kc,
      input logic [5:0] od, input logic [5:0] orow, input logic [5:0] oc,
      input logic [15:0] smp,
      input logic [3:0] vd, input logic [3:0] vr, input logic [3:0] vc);
      voxel_req_type rq;
      rq.kind = kind;
      rq.channel = ch;
      rq.kern_dep = kd;
      rq.kern_row = kr;
      rq.kern_col = kc;
      rq.out_dep = od;
      rq.out_row = orow;
      rq.out_col = oc;
      rq.sample = smp;
      rq.vox_dep = vd;
      rq.vox_row = vr;
      rq.vox_col = vc;
      return rq;
   endfunction

   function automatic void add_row(input voxel_req_type rq, input bit typed,
                                   input logic [31:0] value);
      script_row_type row;
      row.rq = rq;
      row.typed = typed;
      row.value = value;
      script.push_back(row);
   endfunction

   // Pick an output position that lands near the target coordinate.
   function automatic logic [5:0] aim_pos(input int target, input logic [3:0] stride,
                                          input logic [2:0] off, input int dil,
                                          input logic [3:0] pad);
      int p;
      if (stride == 0) return 6'($urandom_range(0, 63));
      p = (target + int'(pad) - int'(off) * dil) / int'(stride);
      if (p < 0) p = 0;
      if (p > 63) p = 63;
      return 6'(p);
   endfunction

   function automatic voxel_req_type random_request();
      voxel_req_type rq;
      int            pick, idx;
      rq = make_req(REQ_ACCUM, 3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom),
                    6'($urandom), 6'($urandom), 6'($urandom), 16'($urandom),
                    4'($urandom), 4'($urandom), 4'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         rq.kind = REQ_IGNORED;
      end else if (pick < 40) begin
         rq.kind = ($urandom_range(0, 1) == 1) ? REQ_READ : REQ_READ_CLEAR;
         if (landed_voxels.size() != 0 && $urandom_range(0, 9) < 6) begin
            idx = landed_voxels[$urandom_range(0, landed_voxels.size() - 1)];
            rq.vox_col = 4'(idx % DEF_VOL_WIDTH);
            rq.vox_row = 4'((idx / DEF_VOL_WIDTH) % DEF_VOL_HEIGHT);
            rq.vox_dep = 4'((idx / (DEF_VOL_WIDTH * DEF_VOL_HEIGHT)) % DEF_VOL_DEPTH);
            rq.channel = 3'(idx / (DEF_VOL_WIDTH * DEF_VOL_HEIGHT * DEF_VOL_DEPTH));
         end
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            rq.out_dep = aim_pos($urandom_range(0, DEF_VOL_DEPTH - 1), geometry.stride_depth,
                                 rq.kern_dep, DEF_DIL_DEPTH, geometry.pad_depth);
            rq.out_row = aim_pos($urandom_range(0, DEF_VOL_HEIGHT - 1), geometry.stride_height,
                                 rq.kern_row, int'(geometry.dilation_height),
                                 geometry.pad_height);
            rq.out_col = aim_pos($urandom_range(0, DEF_VOL_WIDTH - 1), geometry.stride_width,
                                 rq.kern_col, int'(geometry.dilation_width),
                                 geometry.pad_width);
         end else if (pick < 85) begin
            rq.out_dep = 6'($urandom_range(0, 15));
            rq.out_row = 6'($urandom_range(0, 15));
            rq.out_col = 6'($urandom_range(0, 15));
         end
         if ($urandom_range(0, 19) == 0)
            rq.sample = ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
      end
      return rq;
   endfunction

   task automatic push_request(input voxel_req_type rq, input bit typed,
                               input logic [31:0] value);
      logic [31:0] predicted;
      req_type <= rq.kind;
      req_channel <= rq.channel;
      req_kern_dep <= rq.kern_dep;
      req_kern_row <= rq.kern_row;
      req_kern_col <= rq.kern_col;
      req_out_dep <= rq.out_dep;
      req_out_row <= rq.out_row;
      req_out_col <= rq.out_col;
      req_sample <= rq.sample;
      req_vox_dep <= rq.vox_dep;
      req_vox_row <= rq.vox_row;
      req_vox_col <= rq.vox_col;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      if (step_volume(rq, predicted)) pending_voxels.push_back(typed ? value : predicted);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         req_push <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic random_items(input int count);
      repeat (count) push_request(random_request(), 1'b0, '0);
   endtask

   // Hold off until the block is idle: all beats back, trailing accumulates retired.
   task automatic drain_results();
      req_push <= 1'b0;
      while (pending_voxels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input csr_type cfg);
      csr_we <= 1'b1;
      csr_index <= CSR_STRIDE_DEPTH;    csr_wdata <= cfg.stride_depth;    @(posedge clock);
      csr_index <= CSR_STRIDE_HEIGHT;   csr_wdata <= cfg.stride_height;   @(posedge clock);
      csr_index <= CSR_STRIDE_WIDTH;    csr_wdata <= cfg.stride_width;    @(posedge clock);
      csr_index <= CSR_PAD_DEPTH;       csr_wdata <= cfg.pad_depth;       @(posedge clock);
      csr_index <= CSR_PAD_HEIGHT;      csr_wdata <= cfg.pad_height;      @(posedge clock);
      csr_index <= CSR_PAD_WIDTH;       csr_wdata <= cfg.pad_width;       @(posedge clock);
      csr_index <= CSR_DILATION_HEIGHT; csr_wdata <= cfg.dilation_height; @(posedge clock);
      csr_index <= CSR_DILATION_WIDTH;  csr_wdata <= cfg.dilation_width;  @(posedge clock);
      csr_we <= 1'b0;
      geometry = cfg;
      configs_used++;
   endtask

   task automatic run_phase(input csr_type cfg, input int count);
      drain_results();
      write_config(cfg);
      random_items(count);
   endtask

   // Drive one voxel to saturation with repeated hits, then read it out.
   task automatic hammer(input logic [15:0] smp);
      voxel_req_type rq;
      int            td, tr, tc;
      td = $urandom_range(0, DEF_VOL_DEPTH - 1);
      tr = $urandom_range(0, DEF_VOL_HEIGHT - 1);
      tc = $urandom_range(0, DEF_VOL_WIDTH - 1);
      rq = make_req(REQ_ACCUM, 3'($urandom), '0, '0, '0,
                    aim_pos(td, geometry.stride_depth, '0, DEF_DIL_DEPTH, geometry.pad_depth),
                    aim_pos(tr, geometry.stride_height, '0, 1, geometry.pad_height),
                    aim_pos(tc, geometry.stride_width, '0, 1, geometry.pad_width),
                    smp, 4'(td), 4'(tr), 4'(tc));
      repeat (HAMMER_BEATS) push_request(rq, 1'b0, '0);
      rq.kind = REQ_READ;
      push_request(rq, 1'b0, '0);
      rq.kind = REQ_READ_CLEAR;
      push_request(rq, 1'b0, '0);
      rq.kind = REQ_READ;
      push_request(rq, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      if (rsp_pop && !rsp_empty) begin
         if (pending_voxels.size() == 0) begin
            flag_failure($sformatf("unexpected voxel beat %h", rsp_voxel_value));
         end else begin
            want = pending_voxels.pop_front();
            reads_checked++;
            if (rsp_voxel_value !== want)
               flag_failure($sformatf("voxel beat %0d: expected %h, got %h",
                                      reads_checked, want, rsp_voxel_value));
         end
      end
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      stall_tick <= stall_tick + 1;
      if (stall_tick % 48 == 0) stall_mode <= pop_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         POP_ALWAYS: rsp_pop <= 1'b1;
         POP_HALF:   rsp_pop <= ($urandom_range(0, 1) == 1);
         POP_RARE:   rsp_pop <= ($urandom_range(0, 5) == 0);
         default:    rsp_pop <= (stall_tick % 8 < 3);
      endcase
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_IDLE) begin
         $display("no beat moved for %0d cycles", idle_cycles);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      add_row(make_req(REQ_READ, 3'd0, 3'd0, 3'd0, 3'd0, 6'd0, 6'd0, 6'd0, 16'h0000,
                       4'd0, 4'd0, 4'd0), 1'b1, 32'h0000_0000);
      add_row(make_req(REQ_READ, 3'd7, 3'd0, 3'd0, 3'd0, 6'd0, 6'd0, 6'd0, 16'h0000,
                       4'd15, 4'd15, 4'd15), 1'b1, 32'h0000_0000);
      add_row(make_req(REQ_ACCUM, 3'd0, 3'd0, 3'd0, 3'd0, 6'd0, 6'd0, 6'd0, 16'h7FFF,
                       4'd0, 4'd0, 4'd0), 1'b0, '0);
      add_row(make_req(REQ_READ, 3'd0, 3'd0, 3'd0, 3'd0, 6'd0, 6'd0, 6'd0, 16'h0000,
                       4'd0, 4'd0, 4'd0), 1'b1, 32'h007F_FF00);
      add_row(make_req(REQ_ACCUM, 3'd0, 3'd0, 3'd0, 3'd0, 6'd0, 6'd0, 6'd0, 16'h8000,
                       4'd0, 4'd0, 4'd0), 1'b0, '0);
      add_row(make_req(REQ_READ_CLEAR, 3'd0, 3'd0, 3'd0, 3'd0, 6'd0, 6'd0, 6'd0, 16'h0000,
                       4'd0, 4'd0, 4'd0), 1'b1, 32'hFFFF_FF00);
      add_row(make_req(REQ_READ, 3'd0, 3'd0, 3'd0, 3'd0, 6'd0, 6'd0, 6'd0, 16'h0000,
                       4'd0, 4'd0, 4'd0), 1'b1, 32'h0000_0000);
      add_row(make_req(REQ_ACCUM, 3'd7, 3'd7, 3'd7, 3'd7, 6'd8, 6'd8, 6'd8, 16'h0001,
                       4'd0, 4'd0, 4'd0), 1'b0, '0);
      add_row(make_req(REQ_ACCUM, 3'd7, 3'd7, 3'd7, 3'd7, 6'd63, 6'd63, 6'd63, 16'h1234,
                       4'd0, 4'd0, 4'd0), 1'b0, '0);
      add_row(make_req(REQ_READ, 3'd7, 3'd0, 3'd0, 3'd0, 6'd0, 6'd0, 6'd0, 16'h0000,
                       4'd15, 4'd15, 4'd15), 1'b1, 32'h0000_0100);
      add_row(make_req(REQ_IGNORED, 3'd7, 3'd7, 3'd7, 3'd7, 6'd63, 6'd63, 6'd63, 16'hFFFF,
                       4'd15, 4'd15, 4'd15), 1'b0, '0);
      add_row(make_req(REQ_READ_CLEAR, 3'd7, 3'd0, 3'd0, 3'd0, 6'd0, 6'd0, 6'd0, 16'h0000,
                       4'd15, 4'd15, 4'd15), 1'b1, 32'h0000_0100);
      add_row(make_req(REQ_READ, 3'd7, 3'd0, 3'd0, 3'd0, 6'd0, 6'd0, 6'd0, 16'h0000,
                       4'd15, 4'd15, 4'd15), 1'b1, 32'h0000_0000);
      add_row(make_req(REQ_ACCUM, 3'd3, 3'd0, 3'd0, 3'd0, 6'd16, 6'd0, 6'd0, 16'h7FFF,
                       4'd0, 4'd0, 4'd0), 1'b0, '0);
      add_row(make_req(REQ_ACCUM, 3'd3, 3'd0, 3'd7, 3'd7, 6'd15, 6'd8, 6'd8, 16'hFFFF,
                       4'd0, 4'd0, 4'd0), 1'b0, '0);
      add_row(make_req(REQ_ACCUM, 3'd3, 3'd0, 3'd0, 3'd7, 6'd15, 6'd0, 6'd9, 16'h7FFF,
                       4'd0, 4'd0, 4'd0), 1'b0, '0);
      add_row(make_req(REQ_READ, 3'd3, 3'd0, 3'd0, 3'd0, 6'd0, 6'd0, 6'd0, 16'h0000,
                       4'd15, 4'd15, 4'd15), 1'b1, 32'hFFFF_FF00);
      add_row(make_req(REQ_READ, 3'd3, 3'd0, 3'd0, 3'd0, 6'd0, 6'd0, 6'd0, 16'h0000,
                       4'd15, 4'd0, 4'd0), 1'b0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_config(CSR_RESET);
      foreach (script[i]) push_request(script[i].rq, script[i].typed, script[i].value);
      random_items(250);
      hammer(16'h7FFF);
      run_phase(csr_type'(32'h0000_0000), 180);
      run_phase(csr_type'(32'hFFFF_FFFF), 180);
      run_phase(csr_type'(32'h888F_FF88), 180);
      run_phase(csr_type'(32'h1110_0023), 100);
      hammer(16'h8000);
      repeat (3) run_phase(csr_type'($urandom()), 180);
      drain_results();

      $display("sent %0d requests under %0d geometries: %0d accumulates landed, %0d saturated",
               items_sent, configs_used, landed, saturated);
      $display("checked %0d voxel reads, %0d failures", reads_checked, fail_count);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
`default_nettype wire
